/* hdl/size_class_heap_allocator_assert.svh */
// Assertion macros used by the allocator core.
`ifndef SIZE_CLASS_HEAP_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_HEAP_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCHAL_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCHAL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

/* hdl/schal_pkg.sv */
package schal_pkg;

   // Fixed field widths of the item ports.
   localparam int FIELD_W    = 16;
   localparam int CLASS_W    = 8;
   localparam int BUCKET_W   = 4;
   localparam int STATUS_W   = 2;
   localparam int HDR_W      = 12;
   localparam int CAP_W      = 11;
   localparam int SUM_W      = 17;
   localparam int HDR_BYTES  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int BUCKET_COUNT = 16;

   // Payload capacity of each bucket in bytes.
   localparam logic [CAP_W-1:0] BUCKET_CAP [BUCKET_COUNT] = '{
      11'd4, 11'd8, 11'd12, 11'd16, 11'd24, 11'd32, 11'd48, 11'd64,
      11'd96, 11'd128, 11'd192, 11'h100, 11'h180, 11'h200, 11'h300, 11'h400
   };

   // Operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_CLASS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_BIG    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_MEMORY  = 2'd3;

   // Register indexes, taken from paddr bit 2.
   localparam logic REG_HEAP_BEGIN = 1'b0;
   localparam logic REG_HEAP_END   = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // Configuration handed from the register block to the engine.
   typedef struct packed {
      logic                begin_load;
      logic [FIELD_W-1:0]  begin_value;
      logic [FIELD_W-1:0]  heap_end;
   } cfg_type;

endpackage

/* hdl/size_class_heap_allocator.sv */
// Heap allocator with up to sixteen size classes, a free list per class and a
// bump pointer. An item is taken when start is high and busy is low; busy is
// high in the cycle after that. In the accept cycle the engine issues one
// read to the header memory and one to the link memory; in the next cycle it
// updates the list heads, bump pointer and memories and registers the result,
// which shows on the rsp_ ports with rsp_valid for exactly one cycle. The
// receiver cannot stall: every item gives exactly one result, and a new item
// may be accepted in the cycle the result shows, but not while the last item
// is still in lookup waiting on the registered header and link memory reads.
// The header and link memories are not cleared after reset; freeing an
// address that was never allocated is not supported. Configuration must be
// written while idle.
module size_class_heap_allocator import schal_pkg::*; #(
   parameter int ADDR_BITS        = 16,
   parameter int NUM_SIZE_CLASSES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  logic [FIELD_W-1:0]    req_length,
   input  logic [CLASS_W-1:0]    req_object_class,
   input  logic [FIELD_W-1:0]    req_object_address,
   output logic                  rsp_valid,
   output logic [FIELD_W-1:0]    rsp_result_address,
   output logic [BUCKET_W-1:0]   rsp_size_bucket,
   output logic [CLASS_W-1:0]    rsp_old_class,
   output logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type                cfg;
   logic                   hdr_rd_en;
   logic [ADDR_BITS-2:0]   hdr_rd_addr;
   logic [HDR_W-1:0]       hdr_rd_data;
   logic                   hdr_wr_en;
   logic [ADDR_BITS-2:0]   hdr_wr_addr;
   logic [HDR_W-1:0]       hdr_wr_data;
   logic                   link_rd_en;
   logic [ADDR_BITS-2:0]   link_rd_addr;
   logic [ADDR_BITS-1:0]   link_rd_data;
   logic                   link_wr_en;
   logic [ADDR_BITS-2:0]   link_wr_addr;
   logic [ADDR_BITS-1:0]   link_wr_data;

   // Configuration registers.
   schal_csr #(
      .ADDR_BITS (ADDR_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Chunk header store: bucket and class per chunk.
   schal_ram #(
      .WIDTH  (HDR_W),
      .ADDR_W (ADDR_BITS - 1)
   ) u_hdr_ram (
      .clock   (clock),
      .rd_en   (hdr_rd_en),
      .rd_addr (hdr_rd_addr),
      .rd_data (hdr_rd_data),
      .wr_en   (hdr_wr_en),
      .wr_addr (hdr_wr_addr),
      .wr_data (hdr_wr_data)
   );

   // Chunk link store: next header address on a free list.
   schal_ram #(
      .WIDTH  (ADDR_BITS),
      .ADDR_W (ADDR_BITS - 1)
   ) u_link_ram (
      .clock   (clock),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data)
   );

   // Allocation engine.
   schal_core #(
      .ADDR_BITS        (ADDR_BITS),
      .NUM_SIZE_CLASSES (NUM_SIZE_CLASSES)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_length         (req_length),
      .req_object_class   (req_object_class),
      .req_object_address (req_object_address),
      .rsp_valid          (rsp_valid),
      .rsp_result_address (rsp_result_address),
      .rsp_size_bucket    (rsp_size_bucket),
      .rsp_old_class      (rsp_old_class),
      .rsp_status         (rsp_status),
      .hdr_rd_en          (hdr_rd_en),
      .hdr_rd_addr        (hdr_rd_addr),
      .hdr_rd_data        (hdr_rd_data),
      .hdr_wr_en          (hdr_wr_en),
      .hdr_wr_addr        (hdr_wr_addr),
      .hdr_wr_data        (hdr_wr_data),
      .link_rd_en         (link_rd_en),
      .link_rd_addr       (link_rd_addr),
      .link_rd_data       (link_rd_data),
      .link_wr_en         (link_wr_en),
      .link_wr_addr       (link_wr_addr),
      .link_wr_data       (link_wr_data)
   );

endmodule

/* hdl/schal_ram.sv */
module schal_ram #(
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 15
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [2**ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/schal_csr.sv */
module schal_csr import schal_pkg::*; #(
   parameter int ADDR_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   localparam logic [FIELD_W-1:0] ADDR_MASK = FIELD_W'((32'd1 << ADDR_BITS) - 32'd1);

   logic [FIELD_W-1:0] heap_begin_ff;
   logic [FIELD_W-1:0] heap_end_ff;
   logic               wr_access;
   logic [FIELD_W-1:0] wr_value;

   assign wr_access = csr_psel && csr_penable && csr_pwrite;
   assign wr_value  = csr_pwdata[FIELD_W-1:0] & ADDR_MASK;

   // Register writes; addresses are masked to the heap address width.
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_begin_ff <= FIELD_W'(HDR_BYTES) & ADDR_MASK;
         heap_end_ff   <= ADDR_MASK;
      end else if (wr_access) begin
         unique case (csr_paddr[2])
            REG_HEAP_BEGIN: heap_begin_ff <= wr_value;
            REG_HEAP_END:   heap_end_ff   <= wr_value;
            default:        heap_end_ff   <= heap_end_ff;
         endcase
      end
   end

   // Read-back mux.
   always_comb begin
      unique case (csr_paddr[2])
         REG_HEAP_BEGIN: csr_prdata = CSR_DATA_W'(heap_begin_ff);
         REG_HEAP_END:   csr_prdata = CSR_DATA_W'(heap_end_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign csr_pready       = 1'b1;
   assign cfg.begin_load   = wr_access && (csr_paddr[2] == REG_HEAP_BEGIN);
   assign cfg.begin_value  = wr_value;
   assign cfg.heap_end     = heap_end_ff;

endmodule

/* hdl/schal_core.sv */
`include "size_class_heap_allocator_assert.svh"

module schal_core import schal_pkg::*; #(
   parameter int ADDR_BITS        = 16,
   parameter int NUM_SIZE_CLASSES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_operation,
   input  logic [FIELD_W-1:0]   req_length,
   input  logic [CLASS_W-1:0]   req_object_class,
   input  logic [FIELD_W-1:0]   req_object_address,
   output logic                 rsp_valid,
   output logic [FIELD_W-1:0]   rsp_result_address,
   output logic [BUCKET_W-1:0]  rsp_size_bucket,
   output logic [CLASS_W-1:0]   rsp_old_class,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 hdr_rd_en,
   output logic [ADDR_BITS-2:0] hdr_rd_addr,
   input  logic [HDR_W-1:0]     hdr_rd_data,
   output logic                 hdr_wr_en,
   output logic [ADDR_BITS-2:0] hdr_wr_addr,
   output logic [HDR_W-1:0]     hdr_wr_data,
   output logic                 link_rd_en,
   output logic [ADDR_BITS-2:0] link_rd_addr,
   input  logic [ADDR_BITS-1:0] link_rd_data,
   output logic                 link_wr_en,
   output logic [ADDR_BITS-2:0] link_wr_addr,
   output logic [ADDR_BITS-1:0] link_wr_data
);

   localparam int IDX_BITS = $clog2(NUM_SIZE_CLASSES);

   state_type                state_ff, state_in;
   logic [ADDR_BITS-1:0]     free_heads_ff [NUM_SIZE_CLASSES];
   logic [ADDR_BITS-1:0]     bump_ff, bump_in;
   logic                     head_load_in;
   logic [BUCKET_W-1:0]      head_idx_in;
   logic [ADDR_BITS-1:0]     head_value_in;

   // Item registers captured at accept.
   logic                     op_ff;
   logic [CLASS_W-1:0]       class_ff;
   logic [BUCKET_W-1:0]      bucket_ff;
   logic                     zero_class_ff;
   logic                     too_big_ff;
   logic [ADDR_BITS-1:0]     head_ff;
   logic [ADDR_BITS-1:0]     addr_ff;
   logic [ADDR_BITS-1:0]     free_hdr_ff;

   // Result registers.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]       rsp_result_address_ff, rsp_result_address_in;
   logic [BUCKET_W-1:0]      rsp_size_bucket_ff, rsp_size_bucket_in;
   logic [CLASS_W-1:0]       rsp_old_class_ff, rsp_old_class_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic                     accept;
   logic [BUCKET_W-1:0]      alloc_bucket;
   logic                     alloc_too_big;
   logic [ADDR_BITS-1:0]     head_sel;
   logic [ADDR_BITS-1:0]     free_hdr;
   logic [SUM_W-1:0]         carve_end;
   logic                     no_memory;
   logic [BUCKET_W-1:0]      hdr_bucket;
   logic [ADDR_BITS-1:0]     hdr_plus;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Smallest bucket whose capacity holds the requested length.
   always_comb begin
      alloc_bucket  = BUCKET_W'(NUM_SIZE_CLASSES - 1);
      alloc_too_big = (req_length > FIELD_W'(BUCKET_CAP[NUM_SIZE_CLASSES - 1]));
      for (int i = NUM_SIZE_CLASSES - 1; i >= 0; i--) begin
         if (req_length <= FIELD_W'(BUCKET_CAP[i])) begin
            alloc_bucket = BUCKET_W'(i);
         end
      end
   end

   assign head_sel = free_heads_ff[alloc_bucket[IDX_BITS-1:0]];
   assign free_hdr = req_object_address[ADDR_BITS-1:0] - ADDR_BITS'(HDR_BYTES);

   // Memory reads are issued in the accept cycle.
   assign hdr_rd_en    = accept;
   assign hdr_rd_addr  = free_hdr[ADDR_BITS-1:1];
   assign link_rd_en   = accept;
   assign link_rd_addr = head_sel[ADDR_BITS-1:1];

   // Capture the item and its decoded bucket.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_operation;
         class_ff      <= req_object_class;
         bucket_ff     <= alloc_bucket;
         zero_class_ff <= (req_object_class == '0);
         too_big_ff    <= alloc_too_big;
         head_ff       <= head_sel;
         addr_ff       <= req_object_address[ADDR_BITS-1:0];
         free_hdr_ff   <= free_hdr;
      end
   end

   // Carve limit, taken without wrap.
   assign carve_end = SUM_W'(bump_ff) + SUM_W'(BUCKET_CAP[bucket_ff]) + SUM_W'(HDR_BYTES);
   assign no_memory = (carve_end >= SUM_W'(cfg.heap_end));

   // Bucket stored in the header, clamped to the last bucket in use.
   always_comb begin
      hdr_bucket = hdr_rd_data[HDR_W-1:CLASS_W];
      if ({1'b0, hdr_bucket} >= (BUCKET_W + 1)'(NUM_SIZE_CLASSES)) begin
         hdr_bucket = BUCKET_W'(NUM_SIZE_CLASSES - 1);
      end
   end

   // Next state, memory updates and result.
   always_comb begin
      state_in              = state_ff;
      bump_in               = bump_ff;
      head_load_in          = 1'b0;
      head_idx_in           = bucket_ff;
      head_value_in         = head_ff;
      hdr_wr_en             = 1'b0;
      hdr_wr_addr           = head_ff[ADDR_BITS-1:1];
      hdr_wr_data           = {bucket_ff, class_ff};
      link_wr_en            = 1'b0;
      link_wr_addr          = free_hdr_ff[ADDR_BITS-1:1];
      link_wr_data          = free_heads_ff[hdr_bucket[IDX_BITS-1:0]];
      rsp_valid_in          = 1'b0;
      rsp_result_address_in = rsp_result_address_ff;
      rsp_size_bucket_in    = rsp_size_bucket_ff;
      rsp_old_class_in      = rsp_old_class_ff;
      rsp_status_in         = rsp_status_ff;
      hdr_plus              = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in         = ST_IDLE;
            rsp_valid_in     = 1'b1;
            rsp_old_class_in = '0;
            rsp_status_in    = STATUS_OK;
            if (op_ff == OP_FREE) begin
               // Mark the chunk unused and push it onto its bucket's list.
               hdr_wr_en             = 1'b1;
               hdr_wr_addr           = free_hdr_ff[ADDR_BITS-1:1];
               hdr_wr_data           = {hdr_bucket, CLASS_W'(0)};
               link_wr_en            = 1'b1;
               head_load_in          = 1'b1;
               head_idx_in           = hdr_bucket;
               head_value_in         = free_hdr_ff;
               rsp_result_address_in = FIELD_W'(addr_ff);
               rsp_size_bucket_in    = hdr_bucket;
               rsp_old_class_in      = hdr_rd_data[CLASS_W-1:0];
            end else if (zero_class_ff) begin
               rsp_result_address_in = '0;
               rsp_size_bucket_in    = '0;
               rsp_status_in         = STATUS_ZERO_CLASS;
            end else if (too_big_ff) begin
               rsp_result_address_in = '0;
               rsp_size_bucket_in    = '0;
               rsp_status_in         = STATUS_TOO_BIG;
            end else if (head_ff != '0) begin
               // Pop the list head; its link word becomes the new head.
               hdr_wr_en             = 1'b1;
               head_load_in          = 1'b1;
               head_value_in         = link_rd_data;
               hdr_plus              = head_ff + ADDR_BITS'(HDR_BYTES);
               rsp_result_address_in = FIELD_W'(hdr_plus);
               rsp_size_bucket_in    = bucket_ff;
            end else if (no_memory) begin
               rsp_result_address_in = '0;
               rsp_size_bucket_in    = bucket_ff;
               rsp_status_in         = STATUS_NO_MEMORY;
            end else begin
               // Carve a new chunk at the bump pointer.
               hdr_wr_en             = 1'b1;
               hdr_wr_addr           = bump_ff[ADDR_BITS-1:1];
               bump_in               = carve_end[ADDR_BITS-1:0];
               hdr_plus              = bump_ff + ADDR_BITS'(HDR_BYTES);
               rsp_result_address_in = FIELD_W'(hdr_plus);
               rsp_size_bucket_in    = bucket_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cfg.begin_load) begin
         bump_in = cfg.begin_value[ADDR_BITS-1:0];
      end
   end

   // Control registers and list heads.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bump_ff      <= ADDR_BITS'(HDR_BYTES);
         for (int i = 0; i < NUM_SIZE_CLASSES; i++) begin
            free_heads_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bump_ff      <= bump_in;
         if (head_load_in) begin
            free_heads_ff[head_idx_in[IDX_BITS-1:0]] <= head_value_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_result_address_ff <= rsp_result_address_in;
      rsp_size_bucket_ff    <= rsp_size_bucket_in;
      rsp_old_class_ff      <= rsp_old_class_in;
      rsp_status_ff         <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_result_address_ff;
   assign rsp_size_bucket    = rsp_size_bucket_ff;
   assign rsp_old_class      = rsp_old_class_ff;
   assign rsp_status         = rsp_status_ff;

   // Every lookup cycle ends in exactly one result.
   `SCHAL_ASSERT_NEXT(a_lookup_gives_result, clock, reset, state_ff == ST_LOOKUP, rsp_valid_ff)
   // An accepted item goes to lookup and the previous result is withdrawn.
   `SCHAL_ASSERT_NEXT(a_accept_to_lookup, clock, reset, accept, (state_ff == ST_LOOKUP) && !rsp_valid_ff)
   // A failed allocation never hands out an address.
   `SCHAL_ASSERT_IMPLIES(a_fail_no_address, clock, reset, rsp_valid_ff && (rsp_status_ff != STATUS_OK), rsp_result_address_ff == '0)
   // Memory writes happen only in the update cycle.
   `SCHAL_ASSERT_IMPLIES(a_write_in_lookup, clock, reset, hdr_wr_en || link_wr_en, state_ff == ST_LOOKUP)

endmodule

/* bench/testbench.sv */
module testbench import schal_pkg::*;;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_LIMIT = 200;

   // One allocator result, as predicted or as seen on the rsp_ ports.
   typedef struct packed {
      logic [FIELD_W-1:0]  address;
      logic [BUCKET_W-1:0] bucket;
      logic [CLASS_W-1:0]  old_class;
      logic [STATUS_W-1:0] status;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_operation = OP_ALLOC;
   logic [FIELD_W-1:0]    req_length = '0;
   logic [CLASS_W-1:0]    req_object_class = '0;
   logic [FIELD_W-1:0]    req_object_address = '0;
   logic                  rsp_valid;
   logic [FIELD_W-1:0]    rsp_result_address;
   logic [BUCKET_W-1:0]   rsp_size_bucket;
   logic [CLASS_W-1:0]    rsp_old_class;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow copy of the allocator state and registers.
   logic [FIELD_W-1:0] heap_begin_reg;
   logic [FIELD_W-1:0] heap_end_reg;
   logic [FIELD_W-1:0] bump_ptr;
   logic [FIELD_W-1:0] list_head [BUCKET_COUNT];
   logic [HDR_W-1:0]   header_word [int];
   logic [FIELD_W-1:0] link_word [int];

   outcome_type        expected_outcomes [$];
   logic [FIELD_W-1:0] live_objects [$];
   logic [FIELD_W-1:0] known_payloads [$];
   int                 sender_idle_pct = 0;
   int                 error_count = 0;
   int                 cycle_count = 0;

   size_class_heap_allocator dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_length         (req_length),
      .req_object_class   (req_object_class),
      .req_object_address (req_object_address),
      .rsp_valid          (rsp_valid),
      .rsp_result_address (rsp_result_address),
      .rsp_size_bucket    (rsp_size_bucket),
      .rsp_old_class      (rsp_old_class),
      .rsp_status         (rsp_status),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Works out the result of one item and updates the shadow state.
   function automatic outcome_type predict_outcome(logic op, logic [FIELD_W-1:0] len,
                                                   logic [CLASS_W-1:0] cls,
                                                   logic [FIELD_W-1:0] addr);
      outcome_type        res;
      int                 fit;
      int                 b;
      logic [FIELD_W-1:0] hdr;
      logic [FIELD_W:0]   carve_end;
      res = '0;
      // A free reads the header, clears its class and pushes the chunk.
      if (op == OP_FREE) begin
         hdr = FIELD_W'(addr - FIELD_W'(HDR_BYTES));
         res.address = addr;
         res.bucket = header_word[hdr[FIELD_W-1:1]][HDR_W-1:8];
         res.old_class = header_word[hdr[FIELD_W-1:1]][7:0];
         res.status = STATUS_OK;
         header_word[hdr[FIELD_W-1:1]] = {res.bucket, 8'h00};
         link_word[hdr[FIELD_W-1:1]] = list_head[res.bucket];
         list_head[res.bucket] = hdr;
         return res;
      end
      if (cls == '0) begin
         res.status = STATUS_ZERO_CLASS;
         return res;
      end
      // Smallest bucket whose capacity holds the length.
      fit = -1;
      for (b = BUCKET_COUNT - 1; b >= 0; b--) begin
         if (len <= FIELD_W'(BUCKET_CAP[b])) begin
            fit = b;
         end
      end
      if (fit < 0) begin
         res.status = STATUS_TOO_BIG;
         return res;
      end
      res.bucket = fit[BUCKET_W-1:0];
      hdr = list_head[fit];
      if (hdr != '0) begin
         list_head[fit] = link_word[hdr[FIELD_W-1:1]];
      end else begin
         // Carving compares without wrap against the heap end.
         carve_end = (FIELD_W + 1)'({1'b0, bump_ptr} + (FIELD_W + 1)'(BUCKET_CAP[fit])
                                    + (FIELD_W + 1)'(HDR_BYTES));
         if (carve_end >= {1'b0, heap_end_reg}) begin
            res.status = STATUS_NO_MEMORY;
            return res;
         end
         hdr = bump_ptr;
         bump_ptr = carve_end[FIELD_W-1:0];
      end
      header_word[hdr[FIELD_W-1:1]] = {res.bucket, cls};
      res.address = FIELD_W'(hdr + FIELD_W'(HDR_BYTES));
      res.status = STATUS_OK;
      return res;
   endfunction

   task automatic check_field(string what, logic [FIELD_W-1:0] want,
                              logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
         error_count++;
      end
   endtask

   // Sends one item after a random gap and records what it should give.
   task automatic send_item(logic op, logic [FIELD_W-1:0] len, logic [CLASS_W-1:0] cls,
                            logic [FIELD_W-1:0] addr);
      outcome_type want;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      start <= 1'b1;
      req_operation <= op;
      req_length <= len;
      req_object_class <= cls;
      req_object_address <= addr;
      do @(posedge clock); while (busy !== 1'b0);
      want = predict_outcome(op, len, cls, addr);
      expected_outcomes.push_back(want);
      if (op == OP_ALLOC && want.status == STATUS_OK) begin
         live_objects.push_back(want.address);
         known_payloads.push_back(want.address);
      end
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic wait_drained();
      int waited;
      start <= 1'b0;
      waited = 0;
      while (expected_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_outcomes.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  expected_outcomes.size());
         error_count += expected_outcomes.size();
         expected_outcomes.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // Writes a register over the APB port, then reads it back.
   task automatic write_register(logic reg_index, logic [FIELD_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= {{(CSR_DATA_W - FIELD_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (reg_index == REG_HEAP_BEGIN) begin
         heap_begin_reg = value;
         bump_ptr = value;
      end else begin
         heap_end_reg = value;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== {{(CSR_DATA_W - FIELD_W){1'b0}}, value}) begin
         $display("%0t: register %0d read mismatch: expected %0h, got %0h", $time,
                  reg_index, value, csr_prdata);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Lengths at bucket edges with the reset heap settings.
   task automatic test_bucket_mapping();
      send_item(OP_ALLOC, 16'd0, 8'd1, FIELD_W'($urandom));
      send_item(OP_ALLOC, 16'd5, 8'd255, FIELD_W'($urandom));
      send_item(OP_ALLOC, 16'd1024, 8'd128, FIELD_W'($urandom));
      send_item(OP_ALLOC, 16'd193, 8'd2, FIELD_W'($urandom));
      send_item(OP_ALLOC, 16'd97, 8'd127, FIELD_W'($urandom));
   endtask

   // Zero class wins over a length that is too big.
   task automatic test_error_status();
      send_item(OP_ALLOC, 16'd8, 8'd0, FIELD_W'($urandom));
      send_item(OP_ALLOC, 16'd1025, 8'd3, FIELD_W'($urandom));
      send_item(OP_ALLOC, 16'hFFFF, 8'd0, FIELD_W'($urandom));
   endtask

   // A tiny heap starting at zero runs out, then the extreme limits.
   task automatic test_heap_limits();
      wait_drained();
      write_register(REG_HEAP_BEGIN, 16'd0);
      write_register(REG_HEAP_END, 16'd20);
      send_item(OP_ALLOC, 16'd4, 8'd9, FIELD_W'($urandom));
      send_item(OP_ALLOC, 16'd3, 8'd10, FIELD_W'($urandom));
      send_item(OP_ALLOC, 16'd1, 8'd11, FIELD_W'($urandom));
      send_item(OP_ALLOC, 16'd4, 8'd12, FIELD_W'($urandom));
      send_item(OP_ALLOC, 16'd12, 8'd13, FIELD_W'($urandom));
      wait_drained();
      write_register(REG_HEAP_BEGIN, 16'd65534);
      write_register(REG_HEAP_END, 16'd65535);
      send_item(OP_ALLOC, 16'd20, 8'd14, FIELD_W'($urandom));
      wait_drained();
      write_register(REG_HEAP_END, 16'd0);
      send_item(OP_ALLOC, 16'd1000, 8'd15, FIELD_W'($urandom));
      wait_drained();
      write_register(REG_HEAP_BEGIN, 16'h0040);
      write_register(REG_HEAP_END, 16'hFFFF);
   endtask

   // Reuse from the lists, a double free, a free of the chunk whose header is at
   // address zero (the list then looks empty) and a free through an odd address.
   task automatic test_free_and_reuse();
      send_item(OP_FREE, FIELD_W'($urandom), CLASS_W'($urandom), known_payloads[6]);
      send_item(OP_FREE, FIELD_W'($urandom), CLASS_W'($urandom), known_payloads[6]);
      send_item(OP_ALLOC, 16'd1, 8'd20, FIELD_W'($urandom));
      send_item(OP_ALLOC, 16'd2, 8'd21, FIELD_W'($urandom));
      send_item(OP_FREE, FIELD_W'($urandom), CLASS_W'($urandom), known_payloads[5]);
      send_item(OP_ALLOC, 16'd4, 8'd22, FIELD_W'($urandom));
      send_item(OP_FREE, FIELD_W'($urandom), CLASS_W'($urandom),
                known_payloads[4] ^ 16'd1);
      send_item(OP_ALLOC, 16'd128, 8'd23, FIELD_W'($urandom));
   endtask

   // Mostly well-formed allocate and free traffic, with some noise mixed in.
   task automatic test_random_traffic(int count, logic [FIELD_W-1:0] first,
                                      logic [FIELD_W-1:0] limit, int idle_pct);
      int                 pick;
      int                 idx;
      logic [FIELD_W-1:0] len;
      logic [CLASS_W-1:0] cls;
      logic [FIELD_W-1:0] addr;
      wait_drained();
      write_register(REG_HEAP_BEGIN, first);
      write_register(REG_HEAP_END, limit);
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         // Now and then hold off until the block has answered everything.
         if (i % 200 == 199) begin
            wait_drained();
         end
         pick = $urandom_range(0, 99);
         len = FIELD_W'($urandom);
         cls = CLASS_W'($urandom);
         addr = FIELD_W'($urandom);
         if (pick < 35 && live_objects.size() != 0) begin
            idx = $urandom_range(0, live_objects.size() - 1);
            addr = live_objects[idx];
            live_objects.delete(idx);
            send_item(OP_FREE, len, cls, addr);
         end else if (pick < 42 && known_payloads.size() != 0) begin
            // Repeated free, sometimes through the odd twin address.
            addr = known_payloads[$urandom_range(0, known_payloads.size() - 1)];
            if ($urandom_range(0, 1) == 1) begin
               addr = addr ^ 16'd1;
            end
            send_item(OP_FREE, len, cls, addr);
         end else if (pick < 46) begin
            send_item(OP_ALLOC, len, 8'd0, addr);
         end else if (pick < 50) begin
            send_item(OP_ALLOC, FIELD_W'($urandom_range(1025, 65535)),
                      (cls == 0) ? 8'd1 : cls, addr);
         end else begin
            idx = $urandom_range(0, 9);
            if (idx < 6) begin
               len = FIELD_W'($urandom_range(0, 64));
            end else if (idx < 9) begin
               len = FIELD_W'($urandom_range(0, 1024));
            end else begin
               len = FIELD_W'(BUCKET_CAP[$urandom_range(0, BUCKET_COUNT - 1)]);
            end
            send_item(OP_ALLOC, len, (cls == 0) ? 8'd1 : cls, addr);
         end
      end
   endtask

   // Compares each result with the oldest expectation.
   always @(posedge clock) begin : result_check
      outcome_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected result: expected none, got address %0h status %0d",
                     $time, rsp_result_address, rsp_status);
            error_count++;
         end else begin
            want = expected_outcomes.pop_front();
            check_field("result_address", want.address, rsp_result_address);
            check_field("size_bucket", FIELD_W'(want.bucket), FIELD_W'(rsp_size_bucket));
            check_field("old_class", FIELD_W'(want.old_class), FIELD_W'(rsp_old_class));
            check_field("status", FIELD_W'(want.status), FIELD_W'(rsp_status));
         end
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      heap_begin_reg = 16'd2;
      heap_end_reg = 16'hFFFF;
      bump_ptr = 16'd2;
      foreach (list_head[i]) begin
         list_head[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bucket_mapping();
      test_error_status();
      test_heap_limits();
      test_free_and_reuse();
      test_random_traffic(610, 16'h0100, 16'h3000, 13);
      test_random_traffic(610, 16'hC000, 16'hFFFF, 72);
      test_random_traffic(610, 16'h4000, 16'h4800, 0);
      wait_drained();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
